>>> rtl/asts_pkg.sv
// Package for the serial converter transaction sequencer.
// Holds the phase encoding, transaction codes, state and result types.
// No dependencies; used by asts_step.sv and the top level.
package asts_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SEND1 = 3'd1,
        PH_WAIT  = 3'd2,
        PH_SEND2 = 3'd3,
        PH_RECV  = 3'd4
    } t_phase;

    // Transaction codes carried in the op field of a start beat.
    localparam logic [2:0] OP_WRITE_REG  = 3'd0;
    localparam logic [2:0] OP_READ_REG   = 3'd1;
    localparam logic [2:0] OP_SINGLE     = 3'd2;
    localparam logic [2:0] OP_CONTINUOUS = 3'd3;
    localparam logic [2:0] OP_CALIBRATE  = 3'd4;
    localparam logic [2:0] OP_SYNC       = 3'd5;

    // Item kinds.
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    localparam int unsigned FRAME_W = 40;
    localparam int unsigned DATA_W  = 32;

    localparam logic [5:0] LEN_FRAME = 6'd40;
    localparam logic [5:0] LEN_BYTE  = 6'd8;
    localparam logic [5:0] LEN_RECV  = 6'd32;

    localparam logic [7:0]         CAL_BYTE   = 8'h0a;
    localparam logic [FRAME_W-1:0] SYNC_ONES  = 40'hFF_FFFF_FFFF;
    localparam logic [FRAME_W-1:0] SYNC_LAST  = 40'hFF_FFFF_FFFE;
    localparam logic [1:0]         SYNC_FINAL = 2'd3;

    typedef struct packed {
        t_phase              phase;
        logic [5:0]          bit_count;
        logic [FRAME_W-1:0]  send_shift;
        logic [DATA_W-1:0]   recv_shift;
        logic [2:0]          current_op;
        logic [1:0]          sync_repeat;
        logic                sdi_reg;
    } t_state;

    typedef struct packed {
        logic                sdi_level;
        logic                clock_pulse;
        logic                busy_res;
        logic                done_res;
        logic [DATA_W-1:0]   read_data;
        logic                rejected;
    } t_result;

endpackage

>>> rtl/asts_if.sv
// Channel interfaces for the serial converter transaction sequencer.
// asts_in_if carries request beats, asts_out_if carries result beats.
// No dependencies.
interface asts_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [2:0]  op;
    logic [7:0]  command;
    logic [31:0] write_data;
    logic        sdo;

    modport source (output valid, kind, op, command, write_data, sdo, input ready);
    modport sink   (input valid, kind, op, command, write_data, sdo, output ready);
endinterface

interface asts_out_if;
    logic        valid;
    logic        ready;
    logic        sdi_level;
    logic        clock_pulse;
    logic        busy_res;
    logic        done_res;
    logic [31:0] read_data;
    logic        rejected;

    modport source (output valid, sdi_level, clock_pulse, busy_res, done_res, read_data,
                    rejected, input ready);
    modport sink   (input valid, sdi_level, clock_pulse, busy_res, done_res, read_data,
                    rejected, output ready);
endinterface

>>> rtl/adc_serial_transaction_sequencer_core.sv
// Top level of the serial converter transaction sequencer.
// Depends on asts_pkg, asts_if (asts_in_if, asts_out_if) and asts_step.
//
//   channel | dir | beat contents
//   --------+-----+---------------------------------------------------------
//   i_in    | in  | kind, op, command, write_data, sdo
//   o_out   | out | sdi_level, clock_pulse, busy_res, done_res, read_data, rejected
//
// Every accepted beat yields exactly one result beat, in the following cycle.
// A new beat is accepted in every cycle unless the output stalls; the rate is set
// by the single output register, freed in the same cycle that its beat is taken.
// i_rst_n is synchronous and active low; it returns the sequencer to idle
// with SDI high and empties the output register.
// While a result waits with o_out.ready low, i_in.ready is low and the
// sequencer state holds.
module adc_serial_transaction_sequencer_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    asts_in_if.sink          i_in,
    asts_out_if.source       o_out
);

    // Sequencer state: phase, bit counter, send and receive shifters, the
    // current transaction, the sync frame counter and the idle SDI level.
    asts_pkg::t_state  r_state;
    asts_pkg::t_state  n_state;

    // Output register holding the result beat until it is taken.
    asts_pkg::t_result r_result;
    asts_pkg::t_result n_result;
    logic              r_out_valid;

    logic              accept;

    // Space in the output register now, or it is being emptied this cycle.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // All the work for a beat is a single pass of combinational logic from
    // the current state and the incoming fields.
    asts_step u_step (
        .i_state      (r_state),
        .i_kind       (i_in.kind),
        .i_op         (i_in.op),
        .i_command    (i_in.command),
        .i_write_data (i_in.write_data),
        .i_sdo        (i_in.sdo),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    // State advances only on an accepted beat, so stalls leave it untouched.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= asts_pkg::PH_IDLE;
            r_state.bit_count   <= '0;
            r_state.send_shift  <= '0;
            r_state.recv_shift  <= '0;
            r_state.current_op  <= '0;
            r_state.sync_repeat <= '0;
            r_state.sdi_reg     <= 1'b1;
            r_out_valid         <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The result payload needs no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.sdi_level   = r_result.sdi_level;
    assign o_out.clock_pulse = r_result.clock_pulse;
    assign o_out.busy_res    = r_result.busy_res;
    assign o_out.done_res    = r_result.done_res;
    assign o_out.read_data   = r_result.read_data;
    assign o_out.rejected    = r_result.rejected;

endmodule

>>> rtl/asts_step.sv
// Next-state and result logic for one beat of the transaction sequencer.
// Purely combinational; depends on asts_pkg.
module asts_step (
    input  asts_pkg::t_state  i_state,
    input  logic              i_kind,
    input  logic [2:0]        i_op,
    input  logic [7:0]        i_command,
    input  logic [31:0]       i_write_data,
    input  logic              i_sdo,
    output asts_pkg::t_state  o_state,
    output asts_pkg::t_result o_result
);

    asts_pkg::t_state  n_state;
    asts_pkg::t_result n_result;
    logic [5:0]        n_count;
    logic [5:0]        len;

    always_comb begin
        n_state  = i_state;
        n_result = '0;
        n_result.sdi_level = i_state.sdi_reg;
        n_count  = 6'(i_state.bit_count + 6'd1);
        len      = asts_pkg::LEN_BYTE;

        if (i_kind == asts_pkg::KIND_START) begin
            if (i_state.phase != asts_pkg::PH_IDLE || i_op > asts_pkg::OP_SYNC) begin
                n_result.rejected = 1'b1;
            end else begin
                n_state.current_op  = i_op;
                n_state.bit_count   = '0;
                n_state.recv_shift  = '0;
                n_state.sync_repeat = '0;
                n_state.sdi_reg     = 1'b1;
                n_state.send_shift  = {i_command, 32'h0};
                n_state.phase       = asts_pkg::PH_SEND1;
                case (i_op)
                    asts_pkg::OP_WRITE_REG: begin
                        n_state.send_shift = {i_command, i_write_data};
                    end
                    asts_pkg::OP_CONTINUOUS: begin
                        n_state.phase = asts_pkg::PH_WAIT;
                    end
                    asts_pkg::OP_SYNC: begin
                        n_state.send_shift = asts_pkg::SYNC_ONES;
                    end
                    default: begin
                    end
                endcase
            end
            n_result.sdi_level = n_state.sdi_reg;
        end else begin
            case (i_state.phase)
                asts_pkg::PH_SEND1, asts_pkg::PH_SEND2: begin
                    if (i_state.phase == asts_pkg::PH_SEND1 &&
                        (i_state.current_op == asts_pkg::OP_WRITE_REG ||
                         i_state.current_op == asts_pkg::OP_SYNC)) begin
                        len = asts_pkg::LEN_FRAME;
                    end
                    n_result.sdi_level   = i_state.send_shift[asts_pkg::FRAME_W-1];
                    n_result.clock_pulse = 1'b1;
                    n_state.send_shift   = {i_state.send_shift[asts_pkg::FRAME_W-2:0], 1'b0};
                    n_state.bit_count    = n_count;
                    if (n_count >= len) begin
                        n_state.bit_count = '0;
                        n_state.sdi_reg   = 1'b1;
                        if (i_state.phase == asts_pkg::PH_SEND2 ||
                            i_state.current_op == asts_pkg::OP_READ_REG) begin
                            n_state.phase = asts_pkg::PH_RECV;
                        end else if (i_state.current_op == asts_pkg::OP_SINGLE) begin
                            n_state.phase   = asts_pkg::PH_WAIT;
                            n_state.sdi_reg = 1'b0;
                        end else if (i_state.current_op == asts_pkg::OP_CALIBRATE) begin
                            n_state.phase = asts_pkg::PH_WAIT;
                        end else if (i_state.current_op == asts_pkg::OP_SYNC &&
                                     i_state.sync_repeat < asts_pkg::SYNC_FINAL) begin
                            n_state.sync_repeat = 2'(i_state.sync_repeat + 2'd1);
                            n_state.send_shift  =
                                (i_state.sync_repeat == 2'(asts_pkg::SYNC_FINAL - 2'd1))
                                ? asts_pkg::SYNC_LAST : asts_pkg::SYNC_ONES;
                        end else begin
                            n_result.done_res   = 1'b1;
                            n_state.phase       = asts_pkg::PH_IDLE;
                            n_state.sync_repeat = '0;
                        end
                    end
                end
                asts_pkg::PH_WAIT: begin
                    if (!i_sdo) begin
                        n_state.phase     = asts_pkg::PH_SEND2;
                        n_state.bit_count = '0;
                        if (i_state.current_op == asts_pkg::OP_SINGLE) begin
                            n_state.send_shift = '0;
                        end else if (i_state.current_op == asts_pkg::OP_CALIBRATE) begin
                            n_state.send_shift = {asts_pkg::CAL_BYTE, 32'h0};
                        end
                    end
                end
                asts_pkg::PH_RECV: begin
                    n_result.clock_pulse = 1'b1;
                    n_state.recv_shift   = {i_state.recv_shift[asts_pkg::DATA_W-2:0], i_sdo};
                    n_state.bit_count    = n_count;
                    if (n_count >= asts_pkg::LEN_RECV) begin
                        n_result.done_res   = 1'b1;
                        n_result.read_data  = n_state.recv_shift;
                        n_state.phase       = asts_pkg::PH_IDLE;
                        n_state.bit_count   = '0;
                        n_state.sync_repeat = '0;
                        n_state.sdi_reg     = 1'b1;
                    end
                end
                default: begin
                    n_state.phase = asts_pkg::PH_IDLE;
                end
            endcase
        end
        n_result.busy_res = (n_state.phase != asts_pkg::PH_IDLE);
    end

    assign o_state  = n_state;
    assign o_result = n_result;

endmodule

>>> rtl/asts_checker.sv
// Port-level checks for the serial converter transaction sequencer.
// Bound to adc_serial_transaction_sequencer_core; no package dependency.
module asts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_sdi_level,
    input logic        i_clock_pulse,
    input logic        i_busy_res,
    input logic        i_done_res,
    input logic [31:0] i_read_data,
    input logic        i_rejected
);

    // A finished transaction leaves the sequencer idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_done_res |-> !i_busy_res)
        else $error("done beat reports busy");

    // A rejected start never pulses the clock nor finishes anything.
    a_reject_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_rejected |-> !i_clock_pulse && !i_done_res)
        else $error("rejected beat has side effects");

    // Received data only appears on a finishing beat.
    a_data_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_read_data != 32'h0) |-> i_done_res)
        else $error("read data outside a done beat");

    // A stalled result beat holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_read_data)
            && $stable(i_sdi_level) && $stable(i_done_res))
        else $error("stalled result beat changed");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind adc_serial_transaction_sequencer_core asts_checker u_asts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_sdi_level   (o_out.sdi_level),
    .i_clock_pulse (o_out.clock_pulse),
    .i_busy_res    (o_out.busy_res),
    .i_done_res    (o_out.done_res),
    .i_read_data   (o_out.read_data),
    .i_rejected    (o_out.rejected)
);
